>>> sv/hsps_pkg.sv
// hsps_pkg: shared types, syntax step codes and field tables for the SPS parser.
// No dependencies.
`default_nettype none
package hsps_pkg;

   typedef enum logic [5:0] {
      S_HDR, S_PROF, S_CONS, S_LEVEL, S_SPSID, S_CHROMA, S_SEP, S_BITL, S_BITC,
      S_QP, S_SMP, S_SLF, S_LOG2FN, S_POCT, S_POCLSB, S_DPOAZ, S_ONRP, S_OTTB,
      S_NREF, S_OFF, S_MAXREF, S_GAPS, S_WMB, S_HMB, S_FMO, S_MBAFF, S_D8,
      S_CROPF, S_CL, S_CR, S_CT, S_CB, S_VUIF, S_ARP, S_ARIDC, S_SARW, S_SARH,
      S_OVP, S_OVA, S_VST, S_VF, S_CDP, S_COL, S_CLOC, S_CLT, S_CLB, S_TIM,
      S_NUIT, S_TS, S_FIX, S_NALHRD, S_VCLHRD, S_LDH, S_PSP, S_BSR, S_MVOPB,
      S_BRUE, S_DONE
   } step_type;

   typedef enum logic [2:0] {
      CS_IDLE, CS_FEED, CS_DRAIN, CS_DIV, CS_EMIT
   } state_type;

   typedef enum logic [2:0] {
      OP_NONE, OP_TAKE, OP_FEED, OP_DRAIN, OP_DIV, OP_EMIT
   } op_type;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOT_SPS  = 2'd1;
   localparam logic [1:0] ST_UNPARSED = 2'd2;

   localparam logic [4:0] NAL_TYPE_SPS = 5'h7;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  profile;
      logic [7:0]  level;
      logic [31:0] width;
      logic [31:0] height;
      logic [31:0] fps;
   } rsp_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic feed_empty;
      logic end_flag;
      logic parse_done;
      logic div_busy;
      logic out_free;
   } sts_type;

   // field length of each step; zero marks an Exp-Golomb code
   function automatic logic [5:0] step_bits(step_type s);
      logic [5:0] b;
      case (s)
         S_HDR, S_PROF, S_CONS, S_LEVEL, S_ARIDC: b = 6'd8;
         S_SARW, S_SARH:                          b = 6'd16;
         S_VF:                                    b = 6'd4;
         S_COL:                                   b = 6'd24;
         S_NUIT, S_TS:                            b = 6'd32;
         S_SEP, S_QP, S_SMP, S_SLF, S_DPOAZ, S_GAPS, S_FMO, S_MBAFF, S_D8,
         S_CROPF, S_VUIF, S_ARP, S_OVP, S_OVA, S_VST, S_CDP, S_CLOC, S_TIM,
         S_FIX, S_NALHRD, S_VCLHRD, S_LDH, S_PSP, S_BSR:
                                                  b = 6'd1;
         default:                                 b = 6'd0;
      endcase
      return b;
   endfunction

   function automatic logic high_profile(logic [7:0] p);
      return p inside {8'd100, 8'd110, 8'd122, 8'd244, 8'd44, 8'd83, 8'd86,
                       8'd118, 8'd128, 8'd138, 8'd139, 8'd134, 8'd135};
   endfunction

endpackage
`default_nettype wire

>>> sv/hsps_ctrl.sv
// hsps_ctrl: sequencing state machine for the SPS parser.
// Depends on hsps_pkg.
`default_nettype none
module hsps_ctrl
   import hsps_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CS_IDLE:  if (req_valid) state_in = CS_FEED;
         CS_FEED:  if (sts.feed_empty) state_in = sts.end_flag ? CS_DRAIN : CS_IDLE;
         CS_DRAIN: if (sts.parse_done) state_in = sts.div_busy ? CS_DIV : CS_EMIT;
         CS_DIV:   if (!sts.div_busy) state_in = CS_EMIT;
         CS_EMIT:  if (sts.out_free) state_in = CS_IDLE;
         default:  state_in = CS_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      cmd.op    = OP_NONE;
      case (state_ff)
         CS_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) cmd.op = OP_TAKE;
         end
         CS_FEED:  cmd.op = OP_FEED;
         CS_DRAIN: cmd.op = OP_DRAIN;
         CS_DIV:   cmd.op = OP_DIV;
         CS_EMIT:  if (sts.out_free) cmd.op = OP_EMIT;
         default:  cmd.op = OP_NONE;
      endcase
   end

endmodule
`default_nettype wire

>>> sv/hsps_dp.sv
// hsps_dp: start-code buffer, bit reader, Exp-Golomb decoder, SPS field
// registers, serial divider and result register. Depends on hsps_pkg.
`default_nettype none
module hsps_dp
   import hsps_pkg::*;
#(
   parameter int MAX_LEADING_ZEROS = 32
)(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cmd_type cmd,
   input  wire req_type req_data,
   output sts_type      sts,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int LZ_W = $clog2(MAX_LEADING_ZEROS + 1);
   localparam logic [LZ_W-1:0] LZ_MAX = LZ_W'(MAX_LEADING_ZEROS);

   logic [31:0] prefix_ff, prefix_in;
   logic [2:0]  count_ff, count_in;
   logic [39:0] fbuf_ff, fbuf_in;
   logic [5:0]  fbits_ff, fbits_in;
   logic        fend_ff, fend_in;
   step_type    step_ff, step_in;
   logic [LZ_W-1:0] lz_ff, lz_in;
   logic [31:0] acc_ff, acc_in;
   logic [5:0]  left_ff, left_in;
   logic        suffix_ff, suffix_in;
   logic        pend_ff, pend_in;
   logic [31:0] value_ff, value_in;
   logic [31:0] lc_ff, lc_in;
   logic [1:0]  chroma_ff, chroma_in;
   logic        frame_ff, frame_in;
   logic [7:0]  profile_ff, profile_in;
   logic [7:0]  level_ff, level_in;
   logic [31:0] width_ff, width_in;
   logic [31:0] height_ff, height_in;
   logic [31:0] tick_ff, tick_in;
   logic [31:0] tscale_ff, tscale_in;
   logic [31:0] fps_ff, fps_in;
   logic [1:0]  status_ff, status_in;
   logic [31:0] divq_ff, divq_in;
   logic [31:0] divr_ff, divr_in;
   logic [5:0]  divcnt_ff, divcnt_in;
   logic        fix_ff, fix_in;
   logic        rvalid_ff, rvalid_in;
   rsp_type     rsp_ff, rsp_in;

   logic        out_free;
   logic        clear;
   logic        do_bit, at_end, bit_val, do_apply;
   logic [31:0] acc_new, mask, v, sum;
   logic [5:0]  bl;
   logic [31:0] pre_new;
   logic [2:0]  cnt_new;
   logic [32:0] rem_sh, diff;
   logic [31:0] q_new;
   logic [1:0]  crop_sh;
   step_type    n;

   assign out_free = !rvalid_ff || !rsp_stall;
   assign clear    = (cmd.op == OP_EMIT);

   always_comb begin
      prefix_in = prefix_ff;  count_in = count_ff;  fbuf_in = fbuf_ff;
      fbits_in = fbits_ff;    fend_in = fend_ff;    step_in = step_ff;
      lz_in = lz_ff;          acc_in = acc_ff;      left_in = left_ff;
      suffix_in = suffix_ff;  pend_in = pend_ff;    value_in = value_ff;
      lc_in = lc_ff;          chroma_in = chroma_ff; frame_in = frame_ff;
      profile_in = profile_ff; level_in = level_ff; width_in = width_ff;
      height_in = height_ff;  tick_in = tick_ff;    tscale_in = tscale_ff;
      fps_in = fps_ff;        status_in = status_ff; divq_in = divq_ff;
      divr_in = divr_ff;      divcnt_in = divcnt_ff; fix_in = fix_ff;
      do_bit = 1'b0; at_end = 1'b0; bit_val = 1'b0; do_apply = 1'b0;
      acc_new = 32'd0; mask = 32'd0; v = value_ff; sum = 32'd0; bl = 6'd0;
      pre_new = {prefix_ff[23:0], req_data.data_byte};
      cnt_new = count_ff + 3'd1;
      rem_sh = {divr_ff, divq_ff[31]};
      diff = rem_sh - {1'b0, tick_ff};
      q_new = {divq_ff[30:0], !diff[32]};
      crop_sh = 2'd0;
      n = S_DONE;

      case (cmd.op)
         OP_TAKE: begin
            if (count_ff < 3'd4) begin
               prefix_in = pre_new;
               count_in  = cnt_new;
               fend_in   = req_data.last_byte;
               fbits_in  = req_data.last_byte ? {cnt_new, 3'b000} : 6'd0;
               case (cnt_new)
                  3'd1:    fbuf_in = {pre_new[7:0], 32'd0};
                  3'd2:    fbuf_in = {pre_new[15:0], 24'd0};
                  3'd3:    fbuf_in = {pre_new[23:0], 16'd0};
                  default: fbuf_in = {pre_new, 8'd0};
               endcase
            end else if (count_ff == 3'd4) begin
               count_in = 3'd5;
               fend_in  = req_data.last_byte;
               if (prefix_ff == 32'h0000_0001) begin
                  fbuf_in  = {req_data.data_byte, 32'd0};
                  fbits_in = 6'd8;
               end else if (prefix_ff[31:8] == 24'h00_0001) begin
                  fbuf_in  = {prefix_ff[7:0], req_data.data_byte, 24'd0};
                  fbits_in = 6'd16;
               end else begin
                  fbuf_in  = {prefix_ff, req_data.data_byte};
                  fbits_in = 6'd40;
               end
            end else begin
               fbuf_in  = {req_data.data_byte, 32'd0};
               fbits_in = 6'd8;
               fend_in  = req_data.last_byte;
            end
         end
         OP_FEED: begin
            if (pend_ff) begin
               do_apply = 1'b1;
            end else if (fbits_ff != 6'd0) begin
               do_bit   = 1'b1;
               bit_val  = fbuf_ff[39];
               at_end   = fend_ff && (fbits_ff == 6'd1);
               fbuf_in  = {fbuf_ff[38:0], 1'b0};
               fbits_in = fbits_ff - 6'd1;
            end
         end
         OP_DRAIN: begin
            if (pend_ff) begin
               do_apply = 1'b1;
            end else if (step_ff != S_DONE) begin
               if (step_ff == S_OFF && !suffix_ff && lz_ff == '0) begin
                  // offset loop has no data left: skip remaining iterations
                  step_in   = S_MAXREF;
                  acc_in    = 32'd0;
                  lz_in     = '0;
                  suffix_in = 1'b0;
                  left_in   = step_bits(S_MAXREF);
               end else begin
                  do_bit = 1'b1;
                  at_end = 1'b1;
               end
            end
         end
         OP_DIV: begin
            if (divcnt_ff != 6'd0) begin
               divq_in   = q_new;
               divr_in   = diff[32] ? rem_sh[31:0] : diff[31:0];
               divcnt_in = divcnt_ff - 6'd1;
               if (divcnt_ff == 6'd1) fps_in = fix_ff ? {1'b0, q_new[31:1]} : q_new;
            end
         end
         default: ;
      endcase

      // one header bit
      if (do_bit && step_ff != S_DONE) begin
         if (step_bits(step_ff) != 6'd0 || suffix_ff) begin
            acc_new = {acc_ff[30:0], bit_val};
            acc_in  = acc_new;
            bl      = left_ff - {5'd0, left_ff != 6'd0};
            left_in = bl;
            if (bl == 6'd0) begin
               mask     = 32'((33'd1 << lz_ff) - 33'd1);
               value_in = suffix_ff ? mask + acc_new : acc_new;
               pend_in  = 1'b1;
            end
         end else if (!bit_val && !at_end && lz_ff < LZ_MAX) begin
            lz_in = lz_ff + 1'b1;
         end else if (lz_ff == '0) begin
            value_in = 32'd0;
            pend_in  = 1'b1;
         end else begin
            suffix_in = 1'b1;
            acc_in    = 32'd0;
            left_in   = 6'(lz_ff);
         end
      end

      // act on a completed field
      if (do_apply) begin
         pend_in = 1'b0;
         sum     = lc_ff + v;
         case (step_ff)
            S_HDR: begin
               if (v[4:0] != NAL_TYPE_SPS) status_in = ST_NOT_SPS;
               else n = S_PROF;
            end
            S_PROF:   begin profile_in = v[7:0]; n = S_CONS; end
            S_CONS:   n = S_LEVEL;
            S_LEVEL:  begin level_in = v[7:0]; n = S_SPSID; end
            S_SPSID:  n = high_profile(profile_ff) ? S_CHROMA : S_LOG2FN;
            S_CHROMA: begin
               // formats above 3 behave like 0 for cropping
               chroma_in = (v > 32'd3) ? 2'd0 : v[1:0];
               n = (v == 32'd3) ? S_SEP : S_BITL;
            end
            S_SEP:    n = S_BITL;
            S_BITL:   n = S_BITC;
            S_BITC:   n = S_QP;
            S_QP:     n = S_SMP;
            S_SMP:    begin lc_in = 32'd0; n = (v != 32'd0) ? S_SLF : S_LOG2FN; end
            S_SLF: begin
               if (v != 32'd0) status_in = ST_UNPARSED;
               lc_in = lc_ff + 32'd1;
               n = ((lc_ff + 32'd1) >= ((chroma_ff == 2'd3) ? 32'd12 : 32'd8))
                   ? S_LOG2FN : S_SLF;
            end
            S_LOG2FN: n = S_POCT;
            S_POCT:   n = (v == 32'd0) ? S_POCLSB : (v == 32'd1) ? S_DPOAZ : S_MAXREF;
            S_POCLSB: n = S_MAXREF;
            S_DPOAZ:  n = S_ONRP;
            S_ONRP:   n = S_OTTB;
            S_OTTB:   n = S_NREF;
            S_NREF:   begin lc_in = v; n = (v != 32'd0) ? S_OFF : S_MAXREF; end
            S_OFF: begin
               lc_in = lc_ff - 32'd1;
               n = (lc_ff != 32'd1) ? S_OFF : S_MAXREF;
            end
            S_MAXREF: n = S_GAPS;
            S_GAPS:   n = S_WMB;
            S_WMB:    begin width_in = (v + 32'd1) << 4; n = S_HMB; end
            S_HMB:    begin lc_in = v + 32'd1; n = S_FMO; end
            S_FMO: begin
               frame_in  = v[0];
               height_in = v[0] ? (lc_ff << 4) : (lc_ff << 5);
               n = v[0] ? S_D8 : S_MBAFF;
            end
            S_MBAFF:  n = S_D8;
            S_D8:     n = S_CROPF;
            S_CROPF:  n = (v != 32'd0) ? S_CL : S_VUIF;
            S_CL:     begin lc_in = v; n = S_CR; end
            S_CR: begin
               crop_sh  = {1'b0, chroma_ff == 2'd1 || chroma_ff == 2'd2};
               width_in = width_ff - (sum << crop_sh);
               n = S_CT;
            end
            S_CT:     begin lc_in = v; n = S_CB; end
            S_CB: begin
               crop_sh   = 2'({1'b0, !frame_ff}) + 2'({1'b0, chroma_ff == 2'd1});
               height_in = height_ff - (sum << crop_sh);
               n = S_VUIF;
            end
            S_VUIF:   n = (v != 32'd0) ? S_ARP : S_DONE;
            S_ARP:    n = (v != 32'd0) ? S_ARIDC : S_OVP;
            S_ARIDC:  n = (v == 32'd255) ? S_SARW : S_OVP;
            S_SARW:   n = S_SARH;
            S_SARH:   n = S_OVP;
            S_OVP:    n = (v != 32'd0) ? S_OVA : S_VST;
            S_OVA:    n = S_VST;
            S_VST:    n = (v != 32'd0) ? S_VF : S_CLOC;
            S_VF:     n = S_CDP;
            S_CDP:    n = (v != 32'd0) ? S_COL : S_CLOC;
            S_COL:    n = S_CLOC;
            S_CLOC:   n = (v != 32'd0) ? S_CLT : S_TIM;
            S_CLT:    n = S_CLB;
            S_CLB:    n = S_TIM;
            S_TIM:    n = (v != 32'd0) ? S_NUIT : S_NALHRD;
            S_NUIT:   begin tick_in = v; n = S_TS; end
            S_TS:     begin tscale_in = v; n = S_FIX; end
            S_FIX: begin
               // division runs after the parse completes
               fps_in = 32'd0;
               fix_in = v[0];
               if (tick_ff != 32'd0) begin
                  divq_in   = tscale_ff;
                  divr_in   = 32'd0;
                  divcnt_in = 6'd32;
               end
               n = S_NALHRD;
            end
            S_NALHRD: begin
               lc_in = v;
               if (v != 32'd0) status_in = ST_UNPARSED;
               n = S_VCLHRD;
            end
            S_VCLHRD: begin
               if (v != 32'd0) status_in = ST_UNPARSED;
               n = (lc_ff != 32'd0 || v != 32'd0) ? S_LDH : S_PSP;
            end
            S_LDH:    n = S_PSP;
            S_PSP:    n = S_BSR;
            S_BSR:    n = (v != 32'd0) ? S_MVOPB : S_DONE;
            S_MVOPB:  begin lc_in = 32'd0; n = S_BRUE; end
            S_BRUE: begin
               lc_in = lc_ff + 32'd1;
               n = ((lc_ff + 32'd1) >= 32'd6) ? S_DONE : S_BRUE;
            end
            default:  n = S_DONE;
         endcase
         step_in   = n;
         acc_in    = 32'd0;
         lz_in     = '0;
         suffix_in = 1'b0;
         left_in   = step_bits(n);
      end
   end

   always_comb begin
      rsp_in    = rsp_ff;
      rvalid_in = rvalid_ff && rsp_stall;
      if (clear) begin
         rvalid_in      = 1'b1;
         rsp_in.status  = status_ff;
         rsp_in.profile = (status_ff == ST_NOT_SPS) ? 8'd0  : profile_ff;
         rsp_in.level   = (status_ff == ST_NOT_SPS) ? 8'd0  : level_ff;
         rsp_in.width   = (status_ff == ST_NOT_SPS) ? 32'd0 : width_ff;
         rsp_in.height  = (status_ff == ST_NOT_SPS) ? 32'd0 : height_ff;
         rsp_in.fps     = (status_ff == ST_NOT_SPS) ? 32'd0 : fps_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         prefix_ff <= 32'd0;  count_ff <= 3'd0;   fbits_ff <= 6'd0;
         fend_ff <= 1'b0;     step_ff <= S_HDR;   lz_ff <= '0;
         acc_ff <= 32'd0;     left_ff <= step_bits(S_HDR);
         suffix_ff <= 1'b0;   pend_ff <= 1'b0;    lc_ff <= 32'd0;
         chroma_ff <= 2'd1;   frame_ff <= 1'b0;   profile_ff <= 8'd0;
         level_ff <= 8'd0;    width_ff <= 32'd0;  height_ff <= 32'd0;
         tick_ff <= 32'd0;    tscale_ff <= 32'd0; fps_ff <= 32'd0;
         status_ff <= ST_OK;  divcnt_ff <= 6'd0;  fix_ff <= 1'b0;
      end else begin
         prefix_ff <= prefix_in;  count_ff <= count_in;   fbits_ff <= fbits_in;
         fend_ff <= fend_in;      step_ff <= step_in;     lz_ff <= lz_in;
         acc_ff <= acc_in;        left_ff <= left_in;     suffix_ff <= suffix_in;
         pend_ff <= pend_in;      lc_ff <= lc_in;         chroma_ff <= chroma_in;
         frame_ff <= frame_in;    profile_ff <= profile_in; level_ff <= level_in;
         width_ff <= width_in;    height_ff <= height_in; tick_ff <= tick_in;
         tscale_ff <= tscale_in;  fps_ff <= fps_in;       status_ff <= status_in;
         divcnt_ff <= divcnt_in;  fix_ff <= fix_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rvalid_ff <= 1'b0;
      end else begin
         rvalid_ff <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      fbuf_ff  <= fbuf_in;
      value_ff <= value_in;
      divq_ff  <= divq_in;
      divr_ff  <= divr_in;
      rsp_ff   <= rsp_in;
   end

   assign sts.feed_empty = (fbits_ff == 6'd0) && !pend_ff;
   assign sts.end_flag   = fend_ff;
   assign sts.parse_done = (step_ff == S_DONE) && !pend_ff;
   assign sts.div_busy   = (divcnt_ff != 6'd0);
   assign sts.out_free   = out_free;
   assign rsp_valid      = rvalid_ff;
   assign rsp_data       = rsp_ff;

endmodule
`default_nettype wire

>>> sv/h264_sps_header_parser.sv
// h264_sps_header_parser: top level of the H.264 SPS header parser.
// Depends on hsps_pkg, hsps_ctrl and hsps_dp.
//
// One NAL unit arrives a byte per transfer on req_, last byte flagged. A
// leading 00 00 01 or 00 00 00 01 start code is dropped once the unit is
// longer than four bytes (the first four bytes are held until the fifth
// arrives). Header bits are read MSB first, one bit per clock, through the
// SPS syntax including Exp-Golomb ue/se codes, the high-profile branch, POC
// types, cropping and VUI timing; the reader pauses while a byte is taken
// and while a completed field updates the field registers, and the fifth
// byte feeds up to 40 buffered bits. After the last byte the reader runs on
// zero bits until the syntax ends, then, if timing info was present with a
// non-zero tick, a restoring divider yields time_scale / num_units_in_tick.
// One transfer on rsp_ then carries status, profile, level, cropped size
// and fps. The result sits in an output register, so the next unit can
// stream in while it waits to be taken. Emulation-prevention bytes are not
// removed, and scaling-list or HRD contents are not parsed (status 2 flags
// them).
`default_nettype none
module h264_sps_header_parser
   import hsps_pkg::*;
#(
   parameter int MAX_LEADING_ZEROS = 32
)(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   cmd_type cmd;
   sts_type sts;

   // control: take byte, feed bits, drain, divide, emit
   hsps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // all parsing state, the divider and the result register
   hsps_dp #(
      .MAX_LEADING_ZEROS (MAX_LEADING_ZEROS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // an accepted byte always starts a load of the bit buffer
   a_take: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> (cmd.op == OP_TAKE))
      else $error("byte accepted without load");

   // a result is only written when the output register is free
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_EMIT) |-> sts.out_free)
      else $error("result written over a pending one");

   // a written result shows up on the next cycle
   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_EMIT) |=> rsp_valid)
      else $error("result lost");

   // non-SPS results carry zero fields
   a_not_sps: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_NOT_SPS) |->
      (rsp_data.width == 32'd0 && rsp_data.fps == 32'd0 && rsp_data.profile == 8'd0))
      else $error("non-SPS result has fields");
`endif

endmodule
`default_nettype wire
